FILE: rtl/mahsd_pkg.sv
// Shared types, tables and header check for the MPEG audio header sync decoder.
package mahsd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WIN_W     = 32;
    localparam int unsigned LIMIT_W   = 12;
    localparam int unsigned KBPS_W    = 9;
    localparam int unsigned FREQ_W    = 16;
    localparam int unsigned RIDX_W    = 4;
    localparam int unsigned SIDE_W    = 6;
    localparam int unsigned QUO_W     = 12;
    localparam int unsigned NUM_W     = 26;
    localparam int unsigned MULK_W    = 18;
    localparam int unsigned CNT_W     = $clog2(QUO_W);
    localparam int unsigned M_DATA_W  = 48;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd1792;
    localparam logic [MULK_W-1:0]  K_LAYER1    = 18'd12000;
    localparam logic [MULK_W-1:0]  K_LAYER23   = 18'd144000;
    localparam logic [WIN_W-1:0]   SYNC_MASK   = 32'hffe00000;
    localparam logic [WIN_W-1:0]   CRC_MASK    = 32'hffff0000;
    localparam logic [WIN_W-1:0]   CRC_PAT     = 32'hfffe0000;

    localparam logic [1:0] LAYER_I   = 2'd1;
    localparam logic [1:0] LAYER_III = 2'd3;
    localparam logic [1:0] MODE_MONO = 2'd3;

    localparam logic [KBPS_W-1:0] KBPS_TAB [2][3][16] = '{
        '{'{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
            9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
          '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
            9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
          '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
            9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}},
        '{'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
            9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
          '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
            9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
          '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
            9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}}
    };

    localparam logic [FREQ_W-1:0] FREQ_TAB [9] = '{
        16'd44100, 16'd48000, 16'd32000, 16'd22050, 16'd24000,
        16'd16000, 16'd11025, 16'd12000, 16'd8000
    };

    typedef struct packed {
        logic shift;
        logic load_hdr;
        logic mul;
        logic div_step;
        logic load_out;
    } mahsd_cmd_t;

    typedef struct packed {
        logic hdr_match;
        logic div_last;
    } mahsd_status_t;

    function automatic logic header_valid(input logic [WIN_W-1:0] h);
        logic ok;
        ok = 1'b1;
        if ((h & SYNC_MASK) != SYNC_MASK) ok = 1'b0;
        if (h[18:17] == 2'd0) ok = 1'b0;
        if (h[15:12] == 4'hf) ok = 1'b0;
        if (h[15:12] == 4'h0) ok = 1'b0;
        if (h[11:10] == 2'd3) ok = 1'b0;
        if (h[19] && h[18:17] == 2'd3 && h[16]) ok = 1'b0;
        if ((h & CRC_MASK) == CRC_PAT) ok = 1'b0;
        return ok;
    endfunction

endpackage

FILE: rtl/mpeg_audio_header_sync_decode_core.sv
// Top level of the MPEG audio frame header sync and decode block.
//
// Input stream: one byte per transaction on s_tdata; s_tuser set clears the
// four-byte window before that byte is shifted in. Each accepted byte is
// checked against the header sync rules together with the three before it.
// A byte that completes no header produces nothing, and the block stays
// ready for the next byte. A byte that completes a valid header produces one
// output transaction: m_tuser carries decode_ok, m_tdata the decoded header
// fields. The frame size needs a multiply step, twelve restoring divide steps
// and a finish step; the block takes no byte until the finish step is done,
// and the result appears on m_tvalid in the cycle after that.
// The output register holds a finished result while the receiver stalls;
// the block keeps taking bytes, and waits in its finish step only if a
// second header completes before the first result has been taken.
// cfg_wr_en writes the frame size limit (reset 1792); write only while idle.
// Reset (aresetn low, synchronous) clears the window and all handshake state
// and sets the limit to 1792.
module mpeg_audio_header_sync_decode_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [mahsd_pkg::BYTE_W-1:0]          s_tdata,   // [7:0] data_byte
    input  logic                                  s_tuser,   // [0] stream_start
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [1:0] layer, [2] low_sampling, [3] mpeg25, [7:4] rate_index,
    // [16:8] bitrate_kbps, [17] padding, [19:18] channel_mode, [21:20] channels,
    // [22] crc_present, [34:23] frame_bytes, [40:35] side_info_bytes, [47:41] zero
    output logic [mahsd_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                  m_tuser,   // [0] decode_ok
    input  logic                                  cfg_wr_en,
    input  logic [mahsd_pkg::LIMIT_W-1:0]         cfg_wr_data
);

    mahsd_pkg::mahsd_cmd_t    cmd;
    mahsd_pkg::mahsd_status_t status;

    mahsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mahsd_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .data_byte     (s_tdata),
        .stream_start  (s_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .cmd           (cmd),
        .status        (status),
        .out_decode_ok (m_tuser),
        .out_data      (m_tdata)
    );

endmodule

FILE: rtl/mahsd_ctrl.sv
// Controller state machine: byte acceptance, multiply, divide steps, result hand-off.
module mahsd_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  mahsd_pkg::mahsd_status_t status,
    output mahsd_pkg::mahsd_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.shift = 1'b1;
                    if (status.hdr_match) begin
                        cmd.load_hdr = 1'b1;
                        state_next   = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

FILE: rtl/mahsd_datapath.sv
// Datapath: byte window, header decode, frame size multiply and restoring divide, result register.
module mahsd_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [mahsd_pkg::BYTE_W-1:0]          data_byte,
    input  logic                                  stream_start,
    input  logic                                  cfg_wr_en,
    input  logic [mahsd_pkg::LIMIT_W-1:0]         cfg_wr_data,
    input  mahsd_pkg::mahsd_cmd_t                 cmd,
    output mahsd_pkg::mahsd_status_t              status,
    output logic                                  out_decode_ok,
    output logic [mahsd_pkg::M_DATA_W-1:0]        out_data
);

    localparam int unsigned QW = mahsd_pkg::QUO_W;
    localparam int unsigned FW = mahsd_pkg::FREQ_W;

    logic [mahsd_pkg::WIN_W-1:0]   win_reg, win_next;
    logic [mahsd_pkg::LIMIT_W-1:0] limit_reg;

    // decoded header
    logic                          d_lsf, d_m25, d_crc, d_mono;
    logic [1:0]                    d_lay;
    logic [mahsd_pkg::RIDX_W-1:0]  d_ridx;
    logic [mahsd_pkg::KBPS_W-1:0]  d_kbps;
    logic [FW-1:0]                 d_freq, d_den;
    logic [mahsd_pkg::SIDE_W-1:0]  d_side;

    logic                          lsf_reg, m25_reg, crc_reg, pad_reg;
    logic [1:0]                    lay_reg, mode_reg;
    logic [mahsd_pkg::RIDX_W-1:0]  ridx_reg;
    logic [mahsd_pkg::KBPS_W-1:0]  kbps_reg;
    logic [FW-1:0]                 den_reg;
    logic [mahsd_pkg::SIDE_W-1:0]  side_reg;

    logic [mahsd_pkg::NUM_W-1:0]   product;
    logic [FW-1:0]                 rem_reg;
    logic [QW-1:0]                 nlow_reg, quo_reg;
    logic [mahsd_pkg::CNT_W-1:0]   cnt_reg;
    logic [FW:0]                   trial, trial_sub;
    logic                          trial_ge;

    logic [QW-1:0]                 qp, fsize;

    logic                          ok_reg;
    logic [mahsd_pkg::M_DATA_W-1:0] data_reg;

    assign win_next = stream_start ? {{(mahsd_pkg::WIN_W-mahsd_pkg::BYTE_W){1'b0}}, data_byte}
                                   : {win_reg[mahsd_pkg::WIN_W-mahsd_pkg::BYTE_W-1:0], data_byte};

    assign status.hdr_match = mahsd_pkg::header_valid(win_next);
    assign status.div_last  = (cnt_reg == mahsd_pkg::CNT_W'(QW - 1));

    always_comb begin
        if (win_next[20]) begin
            d_lsf = ~win_next[19];
            d_m25 = 1'b0;
        end else begin
            d_lsf = 1'b1;
            d_m25 = 1'b1;
        end
        d_lay  = 2'd0 - win_next[18:17];
        d_crc  = ~win_next[16];
        d_mono = (win_next[7:6] == mahsd_pkg::MODE_MONO);
        if (d_m25) begin
            d_ridx = 4'd6 + {2'b00, win_next[11:10]};
        end else begin
            d_ridx = {2'b00, win_next[11:10]} + (d_lsf ? 4'd3 : 4'd0);
        end
        d_kbps = mahsd_pkg::KBPS_TAB[d_lsf][d_lay - 2'd1][win_next[15:12]];
        d_freq = mahsd_pkg::FREQ_TAB[d_ridx];
        d_den  = d_freq;
        d_side = '0;
        if (d_lay == mahsd_pkg::LAYER_III) begin
            if (d_lsf) begin
                d_den  = {d_freq[FW-2:0], 1'b0};
                d_side = d_mono ? 6'd9 : 6'd17;
            end else begin
                d_side = d_mono ? 6'd17 : 6'd32;
            end
            if (d_crc) begin
                d_side = d_side + 6'd2;
            end
        end
    end

    assign product = mahsd_pkg::NUM_W'(kbps_reg *
        ((lay_reg == mahsd_pkg::LAYER_I) ? mahsd_pkg::K_LAYER1 : mahsd_pkg::K_LAYER23));

    assign trial     = {rem_reg, nlow_reg[QW-1]};
    assign trial_ge  = (trial >= {1'b0, den_reg});
    assign trial_sub = trial - {1'b0, den_reg};

    assign qp    = quo_reg + {{(QW-1){1'b0}}, pad_reg};
    assign fsize = (lay_reg == mahsd_pkg::LAYER_I) ? ({qp[QW-3:0], 2'b00} - 12'd4)
                                                   : (qp - 12'd4);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg   <= '0;
            limit_reg <= mahsd_pkg::LIMIT_RESET;
        end else begin
            if (cmd.shift) begin
                win_reg <= win_next;
            end
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_hdr) begin
            lsf_reg  <= d_lsf;
            m25_reg  <= d_m25;
            crc_reg  <= d_crc;
            pad_reg  <= win_next[9];
            lay_reg  <= d_lay;
            mode_reg <= win_next[7:6];
            ridx_reg <= d_ridx;
            kbps_reg <= d_kbps;
            den_reg  <= d_den;
            side_reg <= d_side;
        end
        if (cmd.mul) begin
            rem_reg  <= FW'(product[mahsd_pkg::NUM_W-1:QW]);
            nlow_reg <= product[QW-1:0];
            quo_reg  <= '0;
            cnt_reg  <= '0;
        end
        if (cmd.div_step) begin
            rem_reg  <= trial_ge ? trial_sub[FW-1:0] : trial[FW-1:0];
            nlow_reg <= {nlow_reg[QW-2:0], 1'b0};
            quo_reg  <= {quo_reg[QW-2:0], trial_ge};
            cnt_reg  <= cnt_reg + 1'b1;
        end
        if (cmd.load_out) begin
            ok_reg   <= (fsize <= limit_reg);
            data_reg <= {7'd0, side_reg, fsize, crc_reg,
                         (mode_reg == mahsd_pkg::MODE_MONO) ? 2'd1 : 2'd2,
                         mode_reg, pad_reg, kbps_reg, ridx_reg, m25_reg, lsf_reg, lay_reg};
        end
    end

    assign out_decode_ok = ok_reg;
    assign out_data      = data_reg;

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the MPEG audio header sync and decode core.
module tb_top;

    localparam int unsigned WATCH_LIMIT  = 4000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned PHASES       = 6;
    localparam int unsigned PHASE_BYTES  = 330;

    typedef struct packed {
        logic [6:0]  spare;
        logic [5:0]  side_bytes;
        logic [11:0] payload_bytes;
        logic        crc;
        logic [1:0]  chans;
        logic [1:0]  mode;
        logic        pad;
        logic [8:0]  kbps;
        logic [3:0]  ridx;
        logic        m25;
        logic        lsf;
        logic [1:0]  layer;
    } hdr_fields_t;

    typedef struct packed {
        logic        hit;
        logic        ok;
        hdr_fields_t f;
    } hdr_pred_t;

    typedef struct packed {
        logic       start;
        logic [7:0] data;
    } byte_item_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [mahsd_pkg::BYTE_W-1:0] s_tdata = '0;   // [7:0] data_byte
    logic s_tuser = 1'b0;                          // [0] stream_start
    logic m_tvalid;
    logic m_tready = 1'b0;
    // [1:0] layer, [2] low_sampling, [3] mpeg25, [7:4] rate_index,
    // [16:8] bitrate_kbps, [17] padding, [19:18] channel_mode, [21:20] channels,
    // [22] crc_present, [34:23] frame_bytes, [40:35] side_info_bytes, [47:41] zero
    logic [mahsd_pkg::M_DATA_W-1:0] m_tdata;
    logic m_tuser;                                 // [0] decode_ok
    logic cfg_wr_en = 1'b0;
    logic [mahsd_pkg::LIMIT_W-1:0] cfg_wr_data = '0;

    mpeg_audio_header_sync_decode_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    int unsigned kbps_v1 [48] = '{
        0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0,
        0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0,
        0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0
    };
    int unsigned kbps_lsf [32] = '{
        0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0,
        0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0
    };
    int unsigned hz_tab [9] = '{
        44100, 48000, 32000, 22050, 24000, 16000, 11025, 12000, 8000
    };

    byte_item_t  pending [$];
    hdr_pred_t   hdr_due [$];
    byte_item_t  next_byte;
    logic [31:0] win = '0;
    logic [mahsd_pkg::LIMIT_W-1:0] size_cap = mahsd_pkg::LIMIT_RESET;
    int unsigned s_idle_pct = 0;
    int unsigned m_idle_pct = 0;
    int unsigned errors = 0;
    int unsigned results_seen = 0;
    int unsigned stall_cycles = 0;
    bit s_go = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic hdr_pred_t decode_header(input logic [31:0] w,
                                                input logic [11:0] cap);
        hdr_pred_t p;
        int unsigned lay, rate, pd, kb, hz, fs, sd;
        p = '0;
        lay = 4 - int'(w[18:17]);
        p.hit = (w[31:21] == 11'h7ff) && (w[18:17] != 2'd0) && (w[15:12] != 4'h0)
                && (w[15:12] != 4'hf) && (w[11:10] != 2'd3)
                && !(w[19] && lay == mahsd_pkg::LAYER_I && w[16])
                && (w[31:16] != 16'hfffe);
        if (!p.hit)
            return p;
        p.f.m25 = ~w[20];
        p.f.lsf = w[20] ? ~w[19] : 1'b1;
        rate = int'(w[11:10]);
        p.f.ridx = 4'(p.f.m25 ? 6 + rate : rate + (p.f.lsf ? 3 : 0));
        p.f.layer = 2'(lay);
        p.f.crc = ~w[16];
        p.f.pad = w[9];
        p.f.mode = w[7:6];
        p.f.chans = (p.f.mode == mahsd_pkg::MODE_MONO) ? 2'd1 : 2'd2;
        pd = int'(w[9]);
        if (p.f.lsf)
            kb = kbps_lsf[(lay == mahsd_pkg::LAYER_I ? 0 : 16) + int'(w[15:12])];
        else
            kb = kbps_v1[(lay - 1) * 16 + int'(w[15:12])];
        hz = hz_tab[p.f.ridx];
        sd = 0;
        if (lay == mahsd_pkg::LAYER_I) begin
            fs = ((kb * 12000 / hz + pd) << 2) - 4;
        end else if (lay != mahsd_pkg::LAYER_III) begin
            fs = kb * 144000 / hz + pd - 4;
        end else begin
            if (p.f.lsf)
                sd = (p.f.chans == 2'd1) ? 9 : 17;
            else
                sd = (p.f.chans == 2'd1) ? 17 : 32;
            if (p.f.crc)
                sd = sd + 2;
            fs = kb * 144000 / (hz << p.f.lsf) + pd - 4;
        end
        p.f.kbps = 9'(kb);
        p.f.payload_bytes = 12'(fs);
        p.f.side_bytes = 6'(sd);
        p.ok = (fs <= cap);
        return p;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        errors++;
    endtask

    task automatic compare_field(input string name, input int unsigned got,
                                 input int unsigned want);
        if (got != want)
            note_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    always @(posedge aclk) begin
        hdr_pred_t   want;
        hdr_fields_t got;
        s_go = aresetn && s_tvalid && s_tready;
        if (s_go) begin
            if (s_tuser)
                win = '0;
            win = {win[23:0], s_tdata};
            want = decode_header(win, size_cap);
            if (want.hit)
                hdr_due.push_back(want);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (hdr_due.size() == 0) begin
                note_mismatch("output transaction with no header pending");
            end else begin
                want = hdr_due.pop_front();
                got = m_tdata;
                compare_field("decode_ok", m_tuser, want.ok);
                compare_field("layer", got.layer, want.f.layer);
                compare_field("low_sampling", got.lsf, want.f.lsf);
                compare_field("mpeg25", got.m25, want.f.m25);
                compare_field("rate_index", got.ridx, want.f.ridx);
                compare_field("bitrate_kbps", got.kbps, want.f.kbps);
                compare_field("padding", got.pad, want.f.pad);
                compare_field("channel_mode", got.mode, want.f.mode);
                compare_field("channels", got.chans, want.f.chans);
                compare_field("crc_present", got.crc, want.f.crc);
                compare_field("frame_bytes", got.payload_bytes, want.f.payload_bytes);
                compare_field("side_info_bytes", got.side_bytes, want.f.side_bytes);
                compare_field("zero bits", got.spare, 0);
            end
            results_seen++;
            stall_cycles = 0;
        end else if (!aresetn || s_go || cfg_wr_en) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCH_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (aresetn && (s_go || !s_tvalid)) begin
            if (pending.size() != 0 && $urandom_range(99) >= s_idle_pct) begin
                next_byte = pending.pop_front();
                s_tdata <= next_byte.data;
                s_tuser <= next_byte.start;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && ($urandom_range(99) >= m_idle_pct);
    end

    // start_at: byte position (0 = sync byte) that carries stream_start, or -1
    task automatic push_header(input logic [31:0] w, input int start_at);
        byte_item_t b;
        for (int i = 0; i < 4; i++) begin
            b.data = w[31 - 8 * i -: 8];
            b.start = (i == start_at);
            pending.push_back(b);
        end
    endtask

    function automatic logic [31:0] make_header();
        logic [31:0] w;
        w = $urandom;
        w[31:21] = '1;
        w[18:17] = ($urandom_range(9) == 0) ? 2'd0 : 2'($urandom_range(3, 1));
        if ($urandom_range(9) == 0)
            w[15:12] = $urandom_range(1) ? 4'hf : 4'h0;
        else
            w[15:12] = 4'($urandom_range(14, 1));
        w[11:10] = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
        if ($urandom_range(19) == 0)
            w[21 + $urandom_range(10)] = 1'b0;
        return w;
    endfunction

    task automatic fill_random(input int unsigned count);
        byte_item_t  b;
        int unsigned r, n;
        n = 0;
        while (n < count) begin
            r = $urandom_range(99);
            if (r < 70) begin
                r = $urandom_range(99);
                if (r < 20)
                    push_header(make_header(), 0);
                else if (r < 23)
                    push_header(make_header(), $urandom_range(3, 1));
                else
                    push_header(make_header(), -1);
                n += 4;
            end else begin
                repeat ($urandom_range(6, 1)) begin
                    b.data = 8'($urandom);
                    b.start = ($urandom_range(19) == 0);
                    pending.push_back(b);
                    n++;
                end
            end
        end
    endtask

    task automatic drain();
        while (pending.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (hdr_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [11:0] value);
        @(negedge aclk);
        cfg_wr_data <= value;
        cfg_wr_en <= 1'b1;
        size_cap = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                drain();
                case (ph)
                    1: write_limit(12'd0);
                    2: write_limit(12'd4095);
                    3: write_limit(12'($urandom_range(4095)));
                    4: write_limit(12'($urandom_range(2877, 44)));
                    default: write_limit(mahsd_pkg::LIMIT_RESET);
                endcase
                @(posedge aclk);
            end
            if (ph < 2) begin
                s_idle_pct = 14;
                m_idle_pct = 77;
            end else if (ph < 4) begin
                s_idle_pct = 77;
                m_idle_pct = 14;
            end else begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end
            if (ph == 0) begin
                push_header(32'hfffb94c4, 0);
                push_header(32'hfffaea00, -1);
                push_header(32'hffe5ea80, -1);
                push_header(32'hfff7e8c0, -1);
                push_header(32'hfffe1000, -1);
                push_header(32'hffea10ff, -1);
                // restart the stream in the middle of a header
                push_header(32'hfffb9044, 2);
            end
            fill_random(PHASE_BYTES);
        end
        drain();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
